FILE: rtl/msgpk_pkg.sv
// Shared constants for the MessagePack str/bin deframer.
`timescale 1ns / 1ps

package msgpk_pkg;

  // Width of the declared payload length (wraps above this).
  localparam int LEN_W = 32;

  // Field widths of one beat.
  localparam int BYTE_W   = 8;
  localparam int EXT_W    = 33;
  localparam int HDR_W    = 3;
  localparam int STATUS_W = 2;
  localparam int TDATA_W  = ((BYTE_W + EXT_W + 7) / 8) * 8;
  localparam int TPAD_W   = TDATA_W - BYTE_W - EXT_W;
  localparam int TUSER_W  = 1 + 1 + STATUS_W;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADSIG = 2'd2;

  // Signature bytes.
  localparam logic [7:0] SIG_FIXSTR_LO = 8'hA0;
  localparam logic [7:0] SIG_FIXSTR_HI = 8'hBF;
  localparam logic [7:0] SIG_STR8      = 8'hD9;
  localparam logic [7:0] SIG_STR16     = 8'hDA;
  localparam logic [7:0] SIG_STR32     = 8'hDB;
  localparam logic [7:0] SIG_BIN8      = 8'hC4;
  localparam logic [7:0] SIG_BIN16     = 8'hC5;
  localparam logic [7:0] SIG_BIN32     = 8'hC6;

  // Header sizes (signature plus length bytes).
  localparam logic [HDR_W-1:0] HDR_FIX = 3'd1;
  localparam logic [HDR_W-1:0] HDR_8   = 3'd2;
  localparam logic [HDR_W-1:0] HDR_16  = 3'd3;
  localparam logic [HDR_W-1:0] HDR_32  = 3'd5;

endpackage

FILE: rtl/msgpack_str_bin_deframer.sv
// Top level of the MessagePack str/bin deframer.
`timescale 1ns / 1ps
//
// Usage:
//   The in_ channel carries the serialized buffer, one byte per beat, with
//   in_tlast high on the last byte available. The block decodes the str/bin
//   signature and big-endian length, then forwards each payload byte as one
//   out_ beat. out_tlast marks the last beat of an object or an error beat;
//   on an ok last beat total_extent holds header plus payload length.
//   Signature and length bytes give no beat, except when they finish an
//   empty object or hit an error (bad signature, buffer ends early).
// Timing:
//   One input register feeds the decode/state logic, which loads one output
//   register that drives the out_ channel. Throughput is one byte per cycle
//   while out_tready holds high; the loop through the state registers
//   (32-bit length countdown) sets the cycle.
// Reset and stall:
//   Synchronous active-low reset returns to idle awaiting a signature and
//   drops any held beat. When the receiver stalls, the output register
//   holds its beat, the input register takes one more byte, then in_tready
//   falls until the output frees up.

module msgpack_str_bin_deframer
  import msgpk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] data_byte
  input  logic               in_tlast,   // buffer_end
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [40:8] total_extent, pad
  output logic [TUSER_W-1:0] out_tuser,  // [0] has_byte, [1] is_text, [3:2] status
  output logic               out_tlast   // object_done
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Input register
  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;

  // Object state
  phase_t           phase_r, phase_nxt;
  logic [2:0]       len_left_r, len_left_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0] pay_left_r, pay_left_nxt;
  logic [HDR_W-1:0] hdr_r, hdr_nxt;
  logic             text_r, text_nxt;

  // Output register
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_has_r;
  logic               out_done_r;
  logic [EXT_W-1:0]   out_ext_r;
  logic               out_text_r;
  logic [STATUS_W-1:0] out_status_r;

  // Result of the current byte
  logic                res_valid;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_has;
  logic                res_done;
  logic [EXT_W-1:0]    res_ext;
  logic                res_text;
  logic [STATUS_W-1:0] res_status;

  logic advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    logic             have_len;
    logic [LEN_W-1:0] len_val;
    logic             is_sig;
    logic [2:0]       left_dec;
    logic [LEN_W-1:0] pay_dec;

    phase_nxt    = phase_r;
    len_left_nxt = len_left_r;
    acc_nxt      = acc_r;
    pay_left_nxt = pay_left_r;
    hdr_nxt      = hdr_r;
    text_nxt     = text_r;

    res_valid  = 1'b0;
    res_byte   = '0;
    res_has    = 1'b0;
    res_done   = 1'b0;
    res_ext    = '0;
    res_text   = 1'b0;
    res_status = ST_OK;

    have_len = 1'b0;
    len_val  = '0;
    is_sig   = 1'b0;
    left_dec = len_left_r - 3'd1;
    pay_dec  = pay_left_r - LEN_W'(1);

    case (phase_r)
      PH_LEN: begin
        acc_nxt      = LEN_W'({acc_r, in_byte_r});
        len_left_nxt = left_dec;
        if (left_dec == 3'd0) begin
          have_len = 1'b1;
          len_val  = acc_nxt;
        end else if (in_last_r) begin
          res_valid  = 1'b1;
          res_done   = 1'b1;
          res_text   = text_r;
          res_status = ST_SHORT;
          phase_nxt  = PH_IDLE;
        end
      end
      PH_PAYLOAD: begin
        pay_left_nxt = pay_dec;
        res_valid    = 1'b1;
        res_text     = text_r;
        if (pay_dec == '0) begin
          res_byte  = in_byte_r;
          res_has   = 1'b1;
          res_done  = 1'b1;
          res_ext   = EXT_W'(hdr_r) + EXT_W'(acc_r);
          phase_nxt = PH_IDLE;
        end else if (in_last_r) begin
          res_done   = 1'b1;
          res_status = ST_SHORT;
          phase_nxt  = PH_IDLE;
        end else begin
          res_byte = in_byte_r;
          res_has  = 1'b1;
        end
      end
      default: begin
        // signature byte; start from a clean state
        acc_nxt      = '0;
        pay_left_nxt = '0;
        len_left_nxt = 3'd0;
        hdr_nxt      = '0;
        text_nxt     = 1'b0;
        if (in_byte_r >= SIG_FIXSTR_LO && in_byte_r <= SIG_FIXSTR_HI) begin
          text_nxt = 1'b1;
          hdr_nxt  = HDR_FIX;
          have_len = 1'b1;
          len_val  = LEN_W'(in_byte_r[4:0]);
          acc_nxt  = len_val;
        end else begin
          is_sig = 1'b1;
          case (in_byte_r)
            SIG_STR8:  begin text_nxt = 1'b1; hdr_nxt = HDR_8;  end
            SIG_BIN8:  begin text_nxt = 1'b0; hdr_nxt = HDR_8;  end
            SIG_STR16: begin text_nxt = 1'b1; hdr_nxt = HDR_16; end
            SIG_BIN16: begin text_nxt = 1'b0; hdr_nxt = HDR_16; end
            SIG_STR32: begin text_nxt = 1'b1; hdr_nxt = HDR_32; end
            SIG_BIN32: begin text_nxt = 1'b0; hdr_nxt = HDR_32; end
            default:   is_sig = 1'b0;
          endcase
          if (is_sig) begin
            len_left_nxt = hdr_nxt - 3'd1;
            phase_nxt    = PH_LEN;
            if (in_last_r) begin
              res_valid  = 1'b1;
              res_done   = 1'b1;
              res_text   = text_nxt;
              res_status = ST_SHORT;
              phase_nxt  = PH_IDLE;
            end
          end else begin
            res_valid  = 1'b1;
            res_done   = 1'b1;
            res_status = ST_BADSIG;
            phase_nxt  = PH_IDLE;
          end
        end
      end
    endcase

    // length known: finish an empty object or start the payload
    if (have_len) begin
      if (len_val == '0) begin
        res_valid  = 1'b1;
        res_done   = 1'b1;
        res_ext    = EXT_W'(hdr_nxt);
        res_text   = text_nxt;
        res_status = ST_OK;
        phase_nxt  = PH_IDLE;
      end else if (in_last_r) begin
        res_valid  = 1'b1;
        res_done   = 1'b1;
        res_text   = text_nxt;
        res_status = ST_SHORT;
        phase_nxt  = PH_IDLE;
      end else begin
        pay_left_nxt = len_val;
        phase_nxt    = PH_PAYLOAD;
      end
    end

    // leaving to idle clears the object state
    if (phase_nxt == PH_IDLE) begin
      len_left_nxt = 3'd0;
      acc_nxt      = '0;
      pay_left_nxt = '0;
      hdr_nxt      = '0;
      text_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      len_left_r  <= 3'd0;
      acc_r       <= '0;
      pay_left_r  <= '0;
      hdr_r       <= '0;
      text_r      <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        phase_r    <= phase_nxt;
        len_left_r <= len_left_nxt;
        acc_r      <= acc_nxt;
        pay_left_r <= pay_left_nxt;
        hdr_r      <= hdr_nxt;
        text_r     <= text_nxt;
      end
      if (advance) begin
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && res_valid) begin
      out_byte_r   <= res_byte;
      out_has_r    <= res_has;
      out_done_r   <= res_done;
      out_ext_r    <= res_ext;
      out_text_r   <= res_text;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{TPAD_W{1'b0}}, out_ext_r, out_byte_r};
  assign out_tuser  = {out_status_r, out_text_r, out_has_r};
  assign out_tlast  = out_done_r;

  // an error beat always ends the object and carries no byte
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_done_r && !out_has_r)
    else $error("error beat without object_done or with data");

  // total extent only appears on the last beat
  a_ext_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |-> out_ext_r == '0)
    else $error("total_extent set on a non-final beat");

  // payload phase always has bytes left to pass
  a_pay_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> pay_left_r != '0)
    else $error("payload phase with nothing left");

  // length phase always has length bytes left to gather
  a_len_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LEN |-> len_left_r != 3'd0 && len_left_r < HDR_32)
    else $error("length phase count out of range");

  // a held output beat stays while the input register is full and stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready && in_valid_r |=> out_valid_r && !$changed(phase_r))
    else $error("state advanced while output stalled");

endmodule

FILE: verif/tb_msgpack_str_bin_deframer.sv
// Self-checking testbench for the MessagePack str/bin deframer.
`timescale 1ns / 1ps

module tb_msgpack_str_bin_deframer;
  import msgpk_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_PAYLOAD
  } deframe_phase_t;

  typedef struct packed {
    logic [7:0]          data;
    logic                last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]          pay;
    logic                has;
    logic                done;
    logic [EXT_W-1:0]    ext;
    logic                txt;
    logic [STATUS_W-1:0] st;
  } res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0] out_tuser;
  logic               out_tlast;

  msgpack_str_bin_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  deframe_phase_t   ph;
  logic [2:0]       len_left;
  logic [LEN_W-1:0] len_acc;
  logic [LEN_W-1:0] pay_left;
  logic [HDR_W-1:0] hdr_sz;
  logic             txt;

  in_beat_t byte_q[$];
  res_t     due_q[$];
  res_t     seen;
  res_t     due;
  res_t     step_res;
  in_beat_t nxt;
  int       errs = 0;
  int       nsent = 0;
  int       in_gap = 0;
  int       out_hold = 0;
  bit       in_calm = 1'b0;
  bit       out_calm = 1'b0;
  logic     in_took = 1'b0;

  function automatic void idle_state();
    ph       = PH_IDLE;
    len_left = '0;
    len_acc  = '0;
    pay_left = '0;
    hdr_sz   = '0;
    txt      = 1'b0;
  endfunction

  function automatic res_t short_res();
    res_t r;
    r      = '0;
    r.done = 1'b1;
    r.txt  = txt;
    r.st   = ST_SHORT;
    idle_state();
    return r;
  endfunction

  function automatic bit length_known(input bit last, output res_t r);
    r = '0;
    if (len_acc == '0) begin
      r.done = 1'b1;
      r.ext  = EXT_W'(hdr_sz);
      r.txt  = txt;
      r.st   = ST_OK;
      idle_state();
      return 1'b1;
    end
    if (last) begin
      r = short_res();
      return 1'b1;
    end
    pay_left = len_acc;
    ph       = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // Advance the deframer by one byte; returns 1 when a beat is due.
  function automatic bit deframe_step(input logic [7:0] b, input bit last, output res_t r);
    r = '0;
    case (ph)
      PH_LEN: begin
        len_acc  = (len_acc << 8) | LEN_W'(b);
        len_left = len_left - 3'd1;
        if (len_left == 3'd0) return length_known(last, r);
        if (last) begin
          r = short_res();
          return 1'b1;
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        pay_left = pay_left - LEN_W'(1);
        if (pay_left == '0) begin
          r.pay  = b;
          r.has  = 1'b1;
          r.done = 1'b1;
          r.ext  = EXT_W'(hdr_sz) + EXT_W'(len_acc);
          r.txt  = txt;
          r.st   = ST_OK;
          idle_state();
          return 1'b1;
        end
        if (last) begin
          r = short_res();
          return 1'b1;
        end
        r.pay = b;
        r.has = 1'b1;
        r.txt = txt;
        r.st  = ST_OK;
        return 1'b1;
      end
      default: begin
        idle_state();
        if (b >= SIG_FIXSTR_LO && b <= SIG_FIXSTR_HI) begin
          txt     = 1'b1;
          hdr_sz  = HDR_FIX;
          len_acc = LEN_W'(b - SIG_FIXSTR_LO);
          return length_known(last, r);
        end
        case (b)
          SIG_STR8:  begin txt = 1'b1; hdr_sz = HDR_8;  end
          SIG_BIN8:  begin txt = 1'b0; hdr_sz = HDR_8;  end
          SIG_STR16: begin txt = 1'b1; hdr_sz = HDR_16; end
          SIG_BIN16: begin txt = 1'b0; hdr_sz = HDR_16; end
          SIG_STR32: begin txt = 1'b1; hdr_sz = HDR_32; end
          SIG_BIN32: begin txt = 1'b0; hdr_sz = HDR_32; end
          default: begin
            idle_state();
            r.done = 1'b1;
            r.st   = ST_BADSIG;
            return 1'b1;
          end
        endcase
        len_left = hdr_sz - 3'd1;
        len_acc  = '0;
        ph       = PH_LEN;
        if (last) begin
          r = short_res();
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string fld, input logic [63:0] want,
                               input logic [63:0] got);
    if (errs < 100)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, want, got);
    errs++;
  endtask

  // Mostly short gaps, a few long ones, none at all while calm.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int len_bytes(input logic [7:0] sig);
    case (sig)
      SIG_STR8, SIG_BIN8:   return 1;
      SIG_STR16, SIG_BIN16: return 2;
      SIG_STR32, SIG_BIN32: return 4;
      default:              return 0;
    endcase
  endfunction

  task automatic push_raw(input logic [7:0] b, input bit last);
    byte_q.push_back('{data: b, last: last});
    nsent++;
  endtask

  // Queue one object; cut >= 0 ends the buffer early at that byte index.
  task automatic send_obj(input logic [7:0] sig, input logic [31:0] n, input longint cut,
                          input bit end_last);
    int          lb;
    longint      total;
    logic [7:0]  b;
    lb = len_bytes(sig);
    if (lb == 0) n = 32'(sig - SIG_FIXSTR_LO);
    total = 1 + lb + longint'(n);
    for (longint i = 0; i < total; i++) begin
      if (i == 0) b = sig;
      else if (i <= lb) b = 8'(n >> (8 * (lb - i)));
      else b = 8'($urandom);
      push_raw(b, (i == cut) || (end_last && i == total - 1));
      if (i == cut) break;
    end
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_tvalid) @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
  endtask

  // Sender: hold the beat until taken, then idle or advance.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        nxt = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tlast  <= nxt.last;
        in_gap = pick_gap(in_calm);
        if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_hold = pick_gap(out_calm);
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      idle_state();
    end else begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready && deframe_step(in_tdata, in_tlast, step_res))
        due_q.push_back(step_res);
      if (out_tvalid && out_tready) begin
        seen.pay  = out_tdata[BYTE_W-1:0];
        seen.ext  = out_tdata[BYTE_W +: EXT_W];
        seen.has  = out_tuser[0];
        seen.txt  = out_tuser[1];
        seen.st   = out_tuser[3:2];
        seen.done = out_tlast;
        if (due_q.size() == 0) begin
          flag_mismatch("unexpected beat", 64'd0, 64'(out_tdata));
        end else begin
          due = due_q.pop_front();
          if (seen.pay !== due.pay)
            flag_mismatch("payload_byte", 64'(due.pay), 64'(seen.pay));
          if (seen.has !== due.has)
            flag_mismatch("has_byte", 64'(due.has), 64'(seen.has));
          if (seen.done !== due.done)
            flag_mismatch("object_done", 64'(due.done), 64'(seen.done));
          if (seen.ext !== due.ext)
            flag_mismatch("total_extent", 64'(due.ext), 64'(seen.ext));
          if (seen.txt !== due.txt)
            flag_mismatch("is_text", 64'(due.txt), 64'(seen.txt));
          if (seen.st !== due.st)
            flag_mismatch("status", 64'(due.st), 64'(seen.st));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [7:0]  sig;
    logic [31:0] n;
    longint      cut;
    int          lb;
    int          r;
    bit          paused;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty objects, bad signatures, every kind, early buffer ends
    send_obj(SIG_FIXSTR_LO, 0, -1, 1'b0);
    send_obj(SIG_FIXSTR_LO, 0, -1, 1'b1);
    push_raw(8'h00, 1'b1);
    push_raw(8'hFF, 1'b0);
    push_raw(8'hC1, 1'b1);
    send_obj(SIG_STR8, 0, -1, 1'b0);
    send_obj(SIG_BIN32, 0, -1, 1'b1);
    send_obj(8'hA3, 0, -1, 1'b1);
    push_raw(SIG_BIN8, 1'b0);
    push_raw(8'd2, 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'hFF, 1'b0);
    send_obj(SIG_STR16, 1, -1, 1'b0);
    send_obj(SIG_BIN16, 2, -1, 1'b0);
    send_obj(SIG_STR32, 3, -1, 1'b1);
    send_obj(SIG_BIN32, 32'hFFFF_FFFF, 6, 1'b0);
    send_obj(SIG_FIXSTR_HI, 0, 0, 1'b0);
    send_obj(SIG_STR8, 5, 0, 1'b0);
    send_obj(SIG_STR16, 5, 1, 1'b0);
    send_obj(SIG_BIN8, 3, 2, 1'b0);
    drain();

    while (nsent < 1350) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: any byte in idle, mostly bad signatures
        push_raw(8'($urandom), 1'($urandom));
      end else begin
        case ($urandom_range(0, 6))
          0: sig = SIG_FIXSTR_LO + 8'($urandom_range(0, 31));
          1: sig = SIG_STR8;
          2: sig = SIG_BIN8;
          3: sig = SIG_STR16;
          4: sig = SIG_BIN16;
          5: sig = SIG_STR32;
          default: sig = SIG_BIN32;
        endcase
        lb = len_bytes(sig);
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(0, 24);
        else if (r < 90) n = $urandom_range(25, 255);
        else n = $urandom;
        if (lb == 1) n = n & 32'hFF;
        else if (lb == 2) n = n & 32'hFFFF;
        if (lb == 0) n = 32'(sig - SIG_FIXSTR_LO);
        cut = -1;
        if (n > 300) cut = longint'($urandom_range(0, 30));
        else if ($urandom_range(0, 99) < 12) cut = longint'($urandom_range(0, lb + n));
        send_obj(sig, n, cut, 1'($urandom));
      end
      if (!paused && nsent > 700) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errs == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
